@@ hdl/aip_pkg.sv @@
// Shared types and constants for the ASCII integer parser.
// Holds the parse phase encoding, the parser state record and the range limits.
// No dependencies.
package aip_pkg;

    typedef enum logic [2:0]
    {
        PH_START,
        PH_AFTER_SIGN,
        PH_ZERO,
        PH_DEC,
        PH_HEX_PREFIX,
        PH_HEX
    } parse_phase_t;

    typedef struct packed
    {
        logic [63:0]  accumulator;
        logic [4:0]   digit_count;
        parse_phase_t parse_phase;
        logic         negative;
        logic         failed;
    } parse_state_t;

    // Target type encoding: bit 2 selects signed, bits 1:0 select 8/16/32/64 bit
    localparam int unsigned TT_SIGNED_BIT = 2;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam logic [4:0] MAX_DEC_DIGITS = 5'd20;
    localparam logic [4:0] MAX_HEX_DIGITS = 5'd16;

    // Largest accumulator that may still take another decimal digit: (2^64-1)/10,
    // and the largest digit allowed when the accumulator sits exactly on it.
    localparam logic [63:0] DEC_LIMIT      = 64'd1844674407370955161;
    localparam logic [3:0]  DEC_LIMIT_LAST = 4'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam parse_state_t STATE_CLEAR = '{
        accumulator: 64'd0,
        digit_count: 5'd0,
        parse_phase: PH_START,
        negative:    1'b0,
        failed:      1'b0
    };

endpackage

@@ hdl/aip_step.sv @@
// Next-state logic for one non-zero character of the string.
// Handles sign, leading zero, hex prefix, decimal and hex digit accumulation.
// Depends on aip_pkg.
module aip_step
(
    input  aip_pkg::parse_state_t cur,
    input  logic [7:0]            character,
    input  logic [2:0]            target_type,
    output aip_pkg::parse_state_t nxt
);

    logic        is_dec;
    logic        is_hex_alpha;
    logic        is_sign;
    logic        is_x;
    logic [3:0]  dec_val;
    logic [3:0]  hex_val;
    logic [63:0] acc_x10;
    logic [63:0] acc_dec;
    logic [63:0] acc_hex;
    logic        dec_ovf;

    assign is_dec       = (character >= aip_pkg::CH_0) && (character <= aip_pkg::CH_9);
    assign is_hex_alpha = (character >= aip_pkg::CH_UA) && (character <= aip_pkg::CH_UF);
    assign is_sign      = (character == aip_pkg::CH_PLUS) || (character == aip_pkg::CH_MINUS);
    assign is_x         = (character == aip_pkg::CH_UX) || (character == aip_pkg::CH_LX);
    assign dec_val      = character[3:0];
    assign hex_val      = is_dec ? character[3:0] : (character[3:0] + 4'd9);

    // x10 as shift-add
    assign acc_x10 = {cur.accumulator[60:0], 3'b000} + {cur.accumulator[62:0], 1'b0};
    assign acc_dec = acc_x10 + {60'd0, dec_val};
    assign acc_hex = {cur.accumulator[59:0], hex_val};

    assign dec_ovf = (cur.digit_count >= aip_pkg::MAX_DEC_DIGITS)
                  || (cur.accumulator > aip_pkg::DEC_LIMIT)
                  || ((cur.accumulator == aip_pkg::DEC_LIMIT)
                      && (dec_val > aip_pkg::DEC_LIMIT_LAST));

    always_comb
    begin
        nxt = cur;
        if (!cur.failed)
        begin
            case (cur.parse_phase)
                aip_pkg::PH_START,
                aip_pkg::PH_AFTER_SIGN:
                begin
                    if ((cur.parse_phase == aip_pkg::PH_START) && is_sign)
                    begin
                        if (!target_type[aip_pkg::TT_SIGNED_BIT])
                        begin
                            nxt.failed = 1'b1;
                        end
                        else
                        begin
                            nxt.negative    = (character == aip_pkg::CH_MINUS);
                            nxt.parse_phase = aip_pkg::PH_AFTER_SIGN;
                        end
                    end
                    else if (!is_dec)
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt.accumulator = {60'd0, dec_val};
                        nxt.digit_count = 5'd1;
                        nxt.parse_phase = (character == aip_pkg::CH_0) ? aip_pkg::PH_ZERO
                                                                       : aip_pkg::PH_DEC;
                    end
                end
                aip_pkg::PH_ZERO,
                aip_pkg::PH_DEC:
                begin
                    if ((cur.parse_phase == aip_pkg::PH_ZERO) && is_x)
                    begin
                        nxt.accumulator = 64'd0;
                        nxt.digit_count = 5'd0;
                        nxt.parse_phase = aip_pkg::PH_HEX_PREFIX;
                    end
                    else if (!is_dec || dec_ovf)
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt.accumulator = acc_dec;
                        nxt.digit_count = cur.digit_count + 5'd1;
                        nxt.parse_phase = aip_pkg::PH_DEC;
                    end
                end
                aip_pkg::PH_HEX_PREFIX,
                aip_pkg::PH_HEX:
                begin
                    if (!(is_dec || is_hex_alpha)
                        || (cur.digit_count >= aip_pkg::MAX_HEX_DIGITS))
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt.accumulator = acc_hex;
                        nxt.digit_count = cur.digit_count + 5'd1;
                        nxt.parse_phase = aip_pkg::PH_HEX;
                    end
                end
                default:
                begin
                    nxt.failed = 1'b1;
                end
            endcase
        end
    end

endmodule

@@ hdl/ascii_integer_parser.sv @@
// Top level of the ASCII integer parser: stream in, one result per string out.
// Depends on aip_pkg and aip_step.
//
// Usage
//   Input channel s_*: one character per transaction. s_tdata[7:0] is the
//   character, s_tuser[2:0] the target type (0..3 unsigned 8/16/32/64 bit,
//   4..7 signed 8/16/32/64 bit). A zero character ends the string.
//   Output channel m_*: one transaction per string, issued for the zero
//   character. m_tdata[63:0] is the value (two's complement, sign-extended,
//   zero on rejection), m_tuser[0] the error flag.
//   Throughput: one character per cycle when not stalled. Each character
//   updates the parser state in the cycle it is taken; the x10 shift-add and
//   the overflow compare on the 64-bit accumulator set the cycle.
//   Result: registered, valid the cycle after the zero character is taken.
//   Stall: the result sits in the output register until m_tready. While it
//   waits, s_tready stays low unless m_tready is high in the same cycle, so
//   the next character is taken as the result leaves.
//   Reset: rst_n clears the parser to start of string and empties the
//   output register.
module ascii_integer_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic [2:0]  s_tuser,   // [2:0] target_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [0:0]  m_tuser    // [0] error
);

    aip_pkg::parse_state_t state_reg;
    aip_pkg::parse_state_t state_next;
    aip_pkg::parse_state_t step_state;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] value_reg;
    logic [63:0] value_next;
    logic        error_reg;
    logic        error_next;

    logic        in_take;
    logic        is_end;

    // finish-stage signals
    logic        fmt_bad;
    logic        range_bad;
    logic        upper_used;
    logic [63:0] neg_lim;
    logic [63:0] mag;
    logic [63:0] fin_value;
    logic        fin_error;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;
    assign is_end   = (s_tdata == aip_pkg::CH_NUL);

    aip_step u_step
    (
        .cur         (state_reg),
        .character   (s_tdata),
        .target_type (s_tuser),
        .nxt         (step_state)
    );

    // ---- range check on the terminating character ----
    assign mag = state_reg.accumulator;

    assign fmt_bad = state_reg.failed
                  || (state_reg.parse_phase == aip_pkg::PH_START)
                  || (state_reg.parse_phase == aip_pkg::PH_AFTER_SIGN)
                  || (state_reg.parse_phase == aip_pkg::PH_HEX_PREFIX);

    always_comb
    begin
        case (s_tuser[1:0])
            aip_pkg::SZ_8:
            begin
                upper_used = (mag[63:8] != 56'd0);
                neg_lim    = 64'h0000_0000_0000_0080;
            end
            aip_pkg::SZ_16:
            begin
                upper_used = (mag[63:16] != 48'd0);
                neg_lim    = 64'h0000_0000_0000_8000;
            end
            aip_pkg::SZ_32:
            begin
                upper_used = (mag[63:32] != 32'd0);
                neg_lim    = 64'h0000_0000_8000_0000;
            end
            aip_pkg::SZ_64:
            begin
                upper_used = 1'b0;
                neg_lim    = 64'h8000_0000_0000_0000;
            end
            default:
            begin
                upper_used = 1'b1;
                neg_lim    = 64'd0;
            end
        endcase
    end

    always_comb
    begin
        if (!s_tuser[aip_pkg::TT_SIGNED_BIT])
        begin
            range_bad = upper_used;
        end
        else if (state_reg.negative)
        begin
            range_bad = (mag > neg_lim);
        end
        else
        begin
            // positive limit is neg_lim - 1
            range_bad = (mag >= neg_lim);
        end
    end

    assign fin_error = fmt_bad || range_bad;
    assign fin_value = fin_error ? 64'd0
                     : ((s_tuser[aip_pkg::TT_SIGNED_BIT] && state_reg.negative)
                        ? (64'd0 - mag) : mag);

    // ---- next state ----
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        error_next     = error_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_take)
        begin
            if (is_end)
            begin
                state_next     = aip_pkg::STATE_CLEAR;
                out_valid_next = 1'b1;
                value_next     = fin_value;
                error_next     = fin_error;
            end
            else
            begin
                state_next = step_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aip_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        error_reg <= error_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = value_reg;
    assign m_tuser[0] = error_reg;

    // ---- assertions ----
    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
        else $error("rejected result carries a non-zero value");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && is_end) |=> m_tvalid)
        else $error("terminator taken but no result presented");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && is_end) |=> ((state_reg.parse_phase == aip_pkg::PH_START)
                                 && !state_reg.failed
                                 && (state_reg.digit_count == 5'd0)))
        else $error("parser state not cleared after terminator");

    a_dec_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.digit_count <= aip_pkg::MAX_DEC_DIGITS))
        else $error("decimal digit count beyond limit");

    a_hex_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg.parse_phase == aip_pkg::PH_HEX)
         || (state_reg.parse_phase == aip_pkg::PH_HEX_PREFIX))
        |-> (state_reg.digit_count <= aip_pkg::MAX_HEX_DIGITS))
        else $error("hex digit count beyond limit");

endmodule
